// ===== rtl/core/polar_two_axis_homing_sequencer_top_macros.svh =====
// Assertion helpers for the homing sequencer.
`ifndef POLAR_TWO_AXIS_HOMING_SEQUENCER_TOP_MACROS_SVH
`define POLAR_TWO_AXIS_HOMING_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTAH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define PTAH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/ptah_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptah_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MAX    = 3'd1,
    PH_MIN    = 3'd2,
    PH_BACK   = 3'd3,
    PH_FIRST  = 3'd4,
    PH_SECOND = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } phase_t;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RHO_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THETA_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_PERIOD  = 3'd4;

  localparam logic [31:0] RHO_LIMIT_RST   = 32'd800000;
  localparam logic [31:0] THETA_LIMIT_RST = 32'd10240000;
  localparam logic [7:0]  COUPLING_RST    = 8'd8;
  localparam logic [15:0] RAD_PERIOD_RST  = 16'd750;
  localparam logic [15:0] ANG_PERIOD_RST  = 16'd400;

  typedef struct packed {
    logic op;
    logic endstop_level;
    logic endstop_edge;
    logic stall_seen;
  } in_item_t;

  typedef struct packed {
    logic               theta_step;
    logic               theta_dir;
    logic               rho_step;
    logic               rho_dir;
    logic [2:0]         phase;
    logic               busy_res;
    logic               homed;
    logic               failed;
    logic signed [31:0] angle_position;
    logic signed [31:0] radius_position;
    logic [31:0]        radial_span;
    logic [31:0]        rotation_span;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/polar_two_axis_homing_sequencer_top.sv =====
// Homing sequencer for a two-axis polar stepper: each accepted transaction is a
// base tick or a start command and yields exactly one result carrying step
// pulses, directions, phase, status, tracked positions and measured spans. One
// transaction is taken per clock while in_ready is high; a transaction passes an input
// register and then a result register, which loads it only once any earlier result is taken,
// and while a result waits one more transaction is held before in_ready drops. The
// step/phase update is a single pass of counter compares and increments
// between those registers. Configuration is taken on any cycle cfg_we is high.
`timescale 1ns / 1ps
`default_nettype none
`include "polar_two_axis_homing_sequencer_top_macros.svh"

module polar_two_axis_homing_sequencer_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  ptah_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output ptah_pkg::out_item_t                  out_data,
  input  wire                                  cfg_we,
  input  wire  [ptah_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ptah_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration
  logic [31:0] rho_limit_r, theta_limit_r;
  logic [7:0]  coupling_div_r;
  logic [15:0] rad_period_r, ang_period_r;

  // sequencer state
  ptah_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] phase_steps_r, phase_steps_nxt;
  logic [7:0]  coupling_cnt_r, coupling_cnt_nxt;
  logic        edge_pend_r, edge_pend_nxt;
  logic        stall_pend_r, stall_pend_nxt;
  logic [15:0] period_cnt_r, period_cnt_nxt;
  logic [31:0] angle_pos_r, angle_pos_nxt;
  logic [31:0] radius_pos_r, radius_pos_nxt;
  logic [31:0] radial_span_r, radial_span_nxt;
  logic [31:0] rotation_span_r, rotation_span_nxt;
  logic        homed_r, homed_nxt;
  logic        theta_dir_r, theta_dir_nxt;
  logic        rho_dir_r, rho_dir_nxt;

  // pipeline
  logic                s1_valid_r;
  ptah_pkg::in_item_t  s1_data_r;
  logic                out_valid_r;
  ptah_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_adv, s1_fire, in_fire;

  logic        t_step, r_step, do_step, fire;
  logic [15:0] period;
  logic [16:0] period_next;
  logic [8:0]  coupling_next;

  assign out_adv   = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_ready  = !s1_valid_r || out_adv;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_limit_r    <= ptah_pkg::RHO_LIMIT_RST;
      theta_limit_r  <= ptah_pkg::THETA_LIMIT_RST;
      coupling_div_r <= ptah_pkg::COUPLING_RST;
      rad_period_r   <= ptah_pkg::RAD_PERIOD_RST;
      ang_period_r   <= ptah_pkg::ANG_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptah_pkg::CFG_RHO_LIMIT:   rho_limit_r    <= cfg_wdata;
        ptah_pkg::CFG_THETA_LIMIT: theta_limit_r  <= cfg_wdata;
        ptah_pkg::CFG_COUPLING:    coupling_div_r <= cfg_wdata[7:0];
        ptah_pkg::CFG_RAD_PERIOD:  rad_period_r   <= cfg_wdata[15:0];
        ptah_pkg::CFG_ANG_PERIOD:  ang_period_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // one transaction's whole update
  always_comb begin
    phase_nxt         = phase_r;
    phase_steps_nxt   = phase_steps_r;
    coupling_cnt_nxt  = coupling_cnt_r;
    period_cnt_nxt    = period_cnt_r;
    angle_pos_nxt     = angle_pos_r;
    radius_pos_nxt    = radius_pos_r;
    radial_span_nxt   = radial_span_r;
    rotation_span_nxt = rotation_span_r;
    homed_nxt         = homed_r;
    theta_dir_nxt     = theta_dir_r;
    rho_dir_nxt       = rho_dir_r;
    edge_pend_nxt     = edge_pend_r | s1_data_r.endstop_edge;
    stall_pend_nxt    = stall_pend_r | s1_data_r.stall_seen;
    t_step            = 1'b0;
    r_step            = 1'b0;
    do_step           = 1'b0;
    period            = (phase_r == ptah_pkg::PH_MAX || phase_r == ptah_pkg::PH_MIN)
                        ? rad_period_r : ang_period_r;
    period_next       = {1'b0, period_cnt_r} + 17'd1;
    fire              = period_next >= {1'b0, period};
    coupling_next     = '0;

    if (s1_data_r.op == ptah_pkg::OP_START) begin
      edge_pend_nxt     = 1'b0;
      stall_pend_nxt    = 1'b0;
      radial_span_nxt   = '0;
      rotation_span_nxt = '0;
      phase_steps_nxt   = '0;
      coupling_cnt_nxt  = '0;
      period_cnt_nxt    = '0;
      rho_dir_nxt       = 1'b1;
      phase_nxt         = ptah_pkg::PH_MAX;
    end else if (phase_r >= ptah_pkg::PH_MAX && phase_r <= ptah_pkg::PH_SECOND) begin
      period_cnt_nxt = fire ? 16'd0 : period_next[15:0];
      if (fire) begin
        do_step = 1'b1;
        unique case (phase_r)
          ptah_pkg::PH_MAX: begin
            if (stall_pend_nxt) begin
              stall_pend_nxt  = 1'b0;
              phase_steps_nxt = '0;
              rho_dir_nxt     = 1'b0;
              phase_nxt       = ptah_pkg::PH_MIN;
              do_step         = 1'b0;
            end else if (phase_steps_r >= rho_limit_r) begin
              phase_nxt = ptah_pkg::PH_ERROR;
              do_step   = 1'b0;
            end
          end
          ptah_pkg::PH_MIN: begin
            if (stall_pend_nxt) begin
              stall_pend_nxt   = 1'b0;
              radial_span_nxt  = phase_steps_r;
              radius_pos_nxt   = '0;
              edge_pend_nxt    = 1'b0;
              phase_steps_nxt  = '0;
              coupling_cnt_nxt = '0;
              do_step          = 1'b0;
              if (s1_data_r.endstop_level) begin
                phase_nxt     = ptah_pkg::PH_BACK;
                theta_dir_nxt = 1'b0;
                rho_dir_nxt   = 1'b0;
              end else begin
                phase_nxt     = ptah_pkg::PH_FIRST;
                theta_dir_nxt = 1'b1;
                rho_dir_nxt   = 1'b1;
              end
            end else if (phase_steps_r >= rho_limit_r) begin
              phase_nxt = ptah_pkg::PH_ERROR;
              do_step   = 1'b0;
            end
          end
          ptah_pkg::PH_BACK: begin
            // off the endstop: switch over and step in the new direction
            if (!s1_data_r.endstop_level) begin
              phase_nxt        = ptah_pkg::PH_FIRST;
              theta_dir_nxt    = 1'b1;
              rho_dir_nxt      = 1'b1;
              phase_steps_nxt  = '0;
              coupling_cnt_nxt = '0;
            end
          end
          ptah_pkg::PH_FIRST: begin
            if (edge_pend_nxt) begin
              edge_pend_nxt    = 1'b0;
              phase_steps_nxt  = '0;
              coupling_cnt_nxt = '0;
              phase_nxt        = ptah_pkg::PH_SECOND;
            end
          end
          default: begin
            if (edge_pend_nxt) begin
              edge_pend_nxt     = 1'b0;
              rotation_span_nxt = phase_steps_r;
              angle_pos_nxt     = '0;
              radius_pos_nxt    = '0;
              homed_nxt         = 1'b1;
              phase_nxt         = ptah_pkg::PH_DONE;
              do_step           = 1'b0;
            end else if (phase_steps_r >= theta_limit_r) begin
              phase_nxt = ptah_pkg::PH_ERROR;
              do_step   = 1'b0;
            end
          end
        endcase

        if (do_step) begin
          if (phase_nxt == ptah_pkg::PH_MAX) begin
            r_step         = 1'b1;
            radius_pos_nxt = radius_pos_r + 32'd1;
          end else if (phase_nxt == ptah_pkg::PH_MIN) begin
            r_step         = 1'b1;
            radius_pos_nxt = radius_pos_r - 32'd1;
          end else begin
            t_step        = 1'b1;
            angle_pos_nxt = (phase_nxt == ptah_pkg::PH_BACK) ? angle_pos_r - 32'd1
                                                            : angle_pos_r + 32'd1;
            coupling_next = {1'b0, coupling_cnt_nxt} + 9'd1;
            if (coupling_next >= {1'b0, coupling_div_r}) begin
              coupling_cnt_nxt = '0;
              r_step           = 1'b1;
              radius_pos_nxt   = (phase_nxt == ptah_pkg::PH_BACK) ? radius_pos_r - 32'd1
                                                                 : radius_pos_r + 32'd1;
            end else begin
              coupling_cnt_nxt = coupling_next[7:0];
            end
          end
          // counts from the restarted value when the phase just moved on
          phase_steps_nxt = phase_steps_nxt + 32'd1;
        end
      end
    end
  end

  always_comb begin
    out_data_nxt.theta_step      = t_step;
    out_data_nxt.theta_dir       = theta_dir_nxt;
    out_data_nxt.rho_step        = r_step;
    out_data_nxt.rho_dir         = rho_dir_nxt;
    out_data_nxt.phase           = phase_nxt;
    out_data_nxt.busy_res        = (phase_nxt >= ptah_pkg::PH_MAX)
                                   && (phase_nxt <= ptah_pkg::PH_SECOND);
    out_data_nxt.homed           = homed_nxt;
    out_data_nxt.failed          = (phase_nxt == ptah_pkg::PH_ERROR);
    out_data_nxt.angle_position  = angle_pos_nxt;
    out_data_nxt.radius_position = radius_pos_nxt;
    out_data_nxt.radial_span     = radial_span_nxt;
    out_data_nxt.rotation_span   = rotation_span_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      phase_r         <= ptah_pkg::PH_IDLE;
      phase_steps_r   <= '0;
      coupling_cnt_r  <= '0;
      edge_pend_r     <= 1'b0;
      stall_pend_r    <= 1'b0;
      period_cnt_r    <= '0;
      angle_pos_r     <= '0;
      radius_pos_r    <= '0;
      radial_span_r   <= '0;
      rotation_span_r <= '0;
      homed_r         <= 1'b0;
      theta_dir_r     <= 1'b0;
      rho_dir_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        phase_r         <= phase_nxt;
        phase_steps_r   <= phase_steps_nxt;
        coupling_cnt_r  <= coupling_cnt_nxt;
        edge_pend_r     <= edge_pend_nxt;
        stall_pend_r    <= stall_pend_nxt;
        period_cnt_r    <= period_cnt_nxt;
        angle_pos_r     <= angle_pos_nxt;
        radius_pos_r    <= radius_pos_nxt;
        radial_span_r   <= radial_span_nxt;
        rotation_span_r <= rotation_span_nxt;
        homed_r         <= homed_nxt;
        theta_dir_r     <= theta_dir_nxt;
        rho_dir_r       <= rho_dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // a step pulse only ever leaves while the sequence is running
  `PTAH_ASSERT_NOW(a_step_only_busy, clk, rst_n,
    out_valid_r && (out_data_r.theta_step || out_data_r.rho_step), out_data_r.busy_res)
  // done is only reachable through a completed calibration
  `PTAH_ASSERT_NOW(a_done_homed, clk, rst_n, phase_r == ptah_pkg::PH_DONE, homed_r)
  // a start transaction always lands in the outward seek
  `PTAH_ASSERT_NEXT(a_start_seek, clk, rst_n,
    s1_fire && s1_data_r.op == ptah_pkg::OP_START,
    phase_r == ptah_pkg::PH_MAX && out_valid_r && out_data_r.rho_dir)

endmodule

`default_nettype wire

// ===== sim/tb_polar_two_axis_homing_sequencer_top.sv =====
`timescale 1ns / 1ps

module tb_polar_two_axis_homing_sequencer_top;

  localparam int CYCLE_LIMIT = 600000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  ptah_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ptah_pkg::out_item_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [ptah_pkg::CFG_IDX_W-1:0]  cfg_index = ptah_pkg::CFG_RHO_LIMIT;
  logic [ptah_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  polar_two_axis_homing_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the sequencer: configuration and state
  logic [31:0] rho_lim, theta_lim;
  logic [7:0]  cpl_div;
  logic [15:0] rad_per, ang_per;

  ptah_pkg::phase_t ph;
  logic [31:0] ph_steps;
  logic [8:0]  cpl_cnt;
  logic [15:0] per_cnt;
  logic        edge_pend, stall_pend, homed_q, th_dir, rh_dir;
  logic [31:0] ang_pos, rad_pos, rad_span, rot_span;

  ptah_pkg::in_item_t  pending_items[$];
  ptah_pkg::out_item_t expected_results[$];

  int  queued_total = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  bit  out_hold_req = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;
  int  out_hold_left = 0;

  task automatic homing_reset();
    rho_lim = ptah_pkg::RHO_LIMIT_RST;
    theta_lim = ptah_pkg::THETA_LIMIT_RST;
    cpl_div = ptah_pkg::COUPLING_RST;
    rad_per = ptah_pkg::RAD_PERIOD_RST;
    ang_per = ptah_pkg::ANG_PERIOD_RST;
    ph = ptah_pkg::PH_IDLE;
    ph_steps = '0;
    cpl_cnt = '0;
    per_cnt = '0;
    edge_pend = 1'b0;
    stall_pend = 1'b0;
    homed_q = 1'b0;
    th_dir = 1'b0;
    rh_dir = 1'b0;
    ang_pos = '0;
    rad_pos = '0;
    rad_span = '0;
    rot_span = '0;
  endtask

  function automatic ptah_pkg::out_item_t homing_predict(ptah_pkg::in_item_t it);
    ptah_pkg::out_item_t r;
    logic        t_step, r_step, do_step, fire, back;
    logic [15:0] per;
    logic [16:0] nxt;
    t_step = 1'b0;
    r_step = 1'b0;
    edge_pend = edge_pend | it.endstop_edge;
    stall_pend = stall_pend | it.stall_seen;
    if (it.op == ptah_pkg::OP_START) begin
      edge_pend = 1'b0;
      stall_pend = 1'b0;
      rad_span = '0;
      rot_span = '0;
      ph_steps = '0;
      cpl_cnt = '0;
      per_cnt = '0;
      rh_dir = 1'b1;
      ph = ptah_pkg::PH_MAX;
    end else if (ph >= ptah_pkg::PH_MAX && ph <= ptah_pkg::PH_SECOND) begin
      per = (ph <= ptah_pkg::PH_MIN) ? rad_per : ang_per;
      nxt = {1'b0, per_cnt} + 17'd1;
      fire = (nxt >= {1'b0, per});
      per_cnt = fire ? 16'd0 : nxt[15:0];
      if (fire) begin
        do_step = 1'b1;
        case (ph)
          ptah_pkg::PH_MAX: begin
            if (stall_pend) begin
              stall_pend = 1'b0;
              ph_steps = '0;
              rh_dir = 1'b0;
              ph = ptah_pkg::PH_MIN;
              do_step = 1'b0;
            end else if (ph_steps >= rho_lim) begin
              ph = ptah_pkg::PH_ERROR;
              do_step = 1'b0;
            end
          end
          ptah_pkg::PH_MIN: begin
            if (stall_pend) begin
              stall_pend = 1'b0;
              rad_span = ph_steps;
              rad_pos = '0;
              edge_pend = 1'b0;
              ph_steps = '0;
              cpl_cnt = '0;
              // endstop level picks whether theta backs off first
              if (it.endstop_level) begin
                ph = ptah_pkg::PH_BACK;
                th_dir = 1'b0;
                rh_dir = 1'b0;
              end else begin
                ph = ptah_pkg::PH_FIRST;
                th_dir = 1'b1;
                rh_dir = 1'b1;
              end
              do_step = 1'b0;
            end else if (ph_steps >= rho_lim) begin
              ph = ptah_pkg::PH_ERROR;
              do_step = 1'b0;
            end
          end
          ptah_pkg::PH_BACK: begin
            if (!it.endstop_level) begin
              ph = ptah_pkg::PH_FIRST;
              th_dir = 1'b1;
              rh_dir = 1'b1;
              ph_steps = '0;
              cpl_cnt = '0;
            end
          end
          ptah_pkg::PH_FIRST: begin
            if (edge_pend) begin
              edge_pend = 1'b0;
              ph_steps = '0;
              cpl_cnt = '0;
              ph = ptah_pkg::PH_SECOND;
            end
          end
          default: begin
            if (edge_pend) begin
              edge_pend = 1'b0;
              rot_span = ph_steps;
              ang_pos = '0;
              rad_pos = '0;
              homed_q = 1'b1;
              ph = ptah_pkg::PH_DONE;
              do_step = 1'b0;
            end else if (ph_steps >= theta_lim) begin
              ph = ptah_pkg::PH_ERROR;
              do_step = 1'b0;
            end
          end
        endcase
        if (do_step) begin
          if (ph == ptah_pkg::PH_MAX) begin
            r_step = 1'b1;
            rad_pos = rad_pos + 32'd1;
          end else if (ph == ptah_pkg::PH_MIN) begin
            r_step = 1'b1;
            rad_pos = rad_pos - 32'd1;
          end else begin
            back = (ph == ptah_pkg::PH_BACK);
            t_step = 1'b1;
            ang_pos = back ? ang_pos - 32'd1 : ang_pos + 32'd1;
            cpl_cnt = cpl_cnt + 9'd1;
            if (cpl_cnt >= {1'b0, cpl_div}) begin
              cpl_cnt = '0;
              r_step = 1'b1;
              rad_pos = back ? rad_pos - 32'd1 : rad_pos + 32'd1;
            end
          end
          ph_steps = ph_steps + 32'd1;
        end
      end
    end
    r.theta_step = t_step;
    r.theta_dir = th_dir;
    r.rho_step = r_step;
    r.rho_dir = rh_dir;
    r.phase = ph;
    r.busy_res = (ph >= ptah_pkg::PH_MAX && ph <= ptah_pkg::PH_SECOND);
    r.homed = homed_q;
    r.failed = (ph == ptah_pkg::PH_ERROR);
    r.angle_position = ang_pos;
    r.radius_position = rad_pos;
    r.radial_span = rad_span;
    r.rotation_span = rot_span;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  // Input side: acceptance and prediction at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(homing_predict(in_data));
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : feed_items
    logic nxt_valid;
    if (rst_n) begin
      nxt_valid = in_valid;
      if (in_valid && in_taken) begin
        nxt_valid = 1'b0;
        in_gap = in_idle_on ? draw_gap() : 0;
      end
      in_taken = 1'b0;
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          nxt_valid = 1'b1;
          in_data <= pending_items.pop_front();
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Result side: back-pressure, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_hold_req) begin
        out_hold_req = 1'b0;
        out_hold_left = 300;
      end
      if (out_taken) begin
        out_taken = 1'b0;
        out_stall = out_idle_on ? draw_gap() : 0;
      end
      if (out_hold_left > 0) begin
        out_hold_left--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    ptah_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      out_taken = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("theta_step", want.theta_step, out_data.theta_step);
        check_field("theta_dir", want.theta_dir, out_data.theta_dir);
        check_field("rho_step", want.rho_step, out_data.rho_step);
        check_field("rho_dir", want.rho_dir, out_data.rho_dir);
        check_field("phase", want.phase, out_data.phase);
        check_field("busy_res", want.busy_res, out_data.busy_res);
        check_field("homed", want.homed, out_data.homed);
        check_field("failed", want.failed, out_data.failed);
        check_field("angle_position", want.angle_position, out_data.angle_position);
        check_field("radius_position", want.radius_position, out_data.radius_position);
        check_field("radial_span", want.radial_span, out_data.radial_span);
        check_field("rotation_span", want.rotation_span, out_data.rotation_span);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("polar_two_axis_homing_sequencer_top regression: fail");
      $finish;
    end
  end

  task automatic push_item(logic op, logic lvl, logic edg, logic stl);
    ptah_pkg::in_item_t it;
    it.op = op;
    it.endstop_level = lvl;
    it.endstop_edge = edg;
    it.stall_seen = stl;
    pending_items.push_back(it);
    queued_total++;
  endtask

  task automatic write_cfg(logic [ptah_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      ptah_pkg::CFG_RHO_LIMIT:   rho_lim = val;
      ptah_pkg::CFG_THETA_LIMIT: theta_lim = val;
      ptah_pkg::CFG_COUPLING:    cpl_div = val[7:0];
      ptah_pkg::CFG_RAD_PERIOD:  rad_per = val[15:0];
      ptah_pkg::CFG_ANG_PERIOD:  ang_per = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // two-stage pipe, let it settle before touching registers
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_noise(int n);
    repeat (n)
      push_item($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)),
                $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  // One well-formed homing attempt with random timing and stray inputs
  task automatic queue_homing_run(int rp, int ap);
    logic lvl;
    push_item(ptah_pkg::OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 8 * rp))
      push_item(ptah_pkg::OP_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                1'b0);
    push_item(ptah_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'b0, 1'b1);
    repeat ($urandom_range(rp, 8 * rp))
      push_item(ptah_pkg::OP_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                1'b0);
    lvl = 1'($urandom_range(0, 1));
    push_item(ptah_pkg::OP_TICK, lvl, 1'b0, 1'b1);
    repeat (rp) push_item(ptah_pkg::OP_TICK, lvl, 1'b0, 1'b0);
    if (lvl)
      repeat ($urandom_range(0, 6 * ap))
        push_item(ptah_pkg::OP_TICK, 1'b1, 1'b0, $urandom_range(0, 7) == 0);
    repeat ($urandom_range(ap, 6 * ap))
      push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, $urandom_range(0, 7) == 0);
    push_item(ptah_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
    repeat ($urandom_range(ap, 10 * ap))
      push_item(ptah_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'b0,
                $urandom_range(0, 7) == 0);
    push_item(ptah_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
    repeat (ap + $urandom_range(0, 2))
      push_item(ptah_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
  endtask

  task automatic run_phase(logic [31:0] rl, logic [31:0] tl, logic [31:0] cd,
                           logic [31:0] rp, logic [31:0] ap, int n_items,
                           bit idle_on, bit hold_out, bit runs_on);
    int target;
    int rp_eff, ap_eff;
    write_cfg(ptah_pkg::CFG_RHO_LIMIT, rl);
    write_cfg(ptah_pkg::CFG_THETA_LIMIT, tl);
    write_cfg(ptah_pkg::CFG_COUPLING, cd);
    write_cfg(ptah_pkg::CFG_RAD_PERIOD, rp);
    write_cfg(ptah_pkg::CFG_ANG_PERIOD, ap);
    in_idle_on = idle_on;
    out_idle_on = idle_on;
    rp_eff = (rp[15:0] == 0) ? 1 : int'(rp[15:0]);
    ap_eff = (ap[15:0] == 0) ? 1 : int'(ap[15:0]);
    target = queued_total + n_items;
    while (queued_total < target) begin
      if (runs_on && $urandom_range(0, 3) != 0)
        queue_homing_run(rp_eff, ap_eff);
      else
        queue_noise($urandom_range(4, 20));
    end
    if (hold_out) begin
      @(posedge clk);
      out_hold_req = 1'b1;
    end
    drain();
  endtask

  initial begin
    homing_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset configuration: long periods, nothing should step yet
    push_item(ptah_pkg::OP_START, 1'b0, 1'b0, 1'b0);
    repeat (5) push_item(ptah_pkg::OP_TICK, 1'b1, 1'b1, 1'b1);
    drain();

    // directed: tight limits, every-theta-step coupling, zero radial period
    write_cfg(ptah_pkg::CFG_RHO_LIMIT, 32'd2);
    write_cfg(ptah_pkg::CFG_THETA_LIMIT, 32'd3);
    write_cfg(ptah_pkg::CFG_COUPLING, 32'd0);
    write_cfg(ptah_pkg::CFG_RAD_PERIOD, 32'd0);
    write_cfg(ptah_pkg::CFG_ANG_PERIOD, 32'd1);
    push_item(ptah_pkg::OP_TICK, 1'b1, 1'b1, 1'b1);   // latched while idle, start clears
    push_item(ptah_pkg::OP_START, 1'b1, 1'b1, 1'b1);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);   // radial limit hit
    push_item(ptah_pkg::OP_TICK, 1'b1, 1'b1, 1'b1);   // error holds
    push_item(ptah_pkg::OP_START, 1'b0, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b1);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b1, 1'b0, 1'b1);   // on the endstop: back off
    push_item(ptah_pkg::OP_TICK, 1'b1, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);   // off the endstop, steps in first edge
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b1, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);   // angular limit hit
    push_item(ptah_pkg::OP_START, 1'b1, 1'b0, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b1);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b0, 1'b1);   // clear of endstop: straight to first edge
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b1, 1'b0);
    push_item(ptah_pkg::OP_TICK, 1'b0, 1'b1, 1'b0);   // second edge: homed
    push_item(ptah_pkg::OP_TICK, 1'b1, 1'b1, 1'b1);
    push_item(ptah_pkg::OP_START, 1'b1, 1'b1, 1'b1);  // restart keeps homed
    drain();

    run_phase($urandom_range(4, 40), $urandom_range(8, 60), $urandom_range(1, 4),
              1, 1, 220, 1'b1, 1'b0, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 3, 2, 200, 1'b0, 1'b1, 1'b1);
    run_phase(1, 1, 1, 2, 3, 120, 1'b1, 1'b0, 1'b1);
    run_phase($urandom, $urandom, $urandom_range(0, 255), 32'h0000_FFFF, 32'h0000_FFFF, 40,
              1'b1, 1'b0, 1'b0);
    run_phase($urandom_range(2, 30), $urandom_range(2, 60), $urandom_range(0, 6),
              $urandom_range(1, 3), $urandom_range(1, 3), 230, 1'b0, 1'b0, 1'b1);
    run_phase($urandom_range(3, 50), $urandom_range(5, 80), $urandom_range(0, 3),
              $urandom_range(1, 2), $urandom_range(1, 2), 200, 1'b1, 1'b0, 1'b1);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("polar_two_axis_homing_sequencer_top regression: pass");
    else
      $display("polar_two_axis_homing_sequencer_top regression: fail");
    $finish;
  end

endmodule
